/* rtl/mat_pkg.sv */
// Shared constants and types for the motion activity tracker.
// Used by every module under rtl; depends on nothing else.
`default_nettype none

package mat_pkg;

    // Default number of motion levels held in the history window.
    localparam int HISTORY_DEPTH_DEF = 100;

    // Field widths.
    localparam int SAMPLE_W = 16;
    localparam int MAG_W    = 16;
    localparam int LEVEL_W  = 32;
    localparam int SUMSQ_W  = 32;
    localparam int ALPHA_W  = 16;

    // Multiplier operand and product widths.
    localparam int MUL_A_W = ALPHA_W + 1;
    localparam int MUL_B_W = LEVEL_W;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // Reset value of the smoothing weight (about 0.1 in Q0.16).
    localparam logic [ALPHA_W-1:0] ALPHA_RESET = 16'd6554;

    // One root digit comes out per step, so a 32-bit radicand takes 16 steps.
    localparam int ROOT_STEPS = SUMSQ_W / 2;

    // Operations of the shared shift-subtract unit.
    typedef enum logic {
        OP_ROOT = 1'b0,
        OP_DIV  = 1'b1
    } op_t;

    // Request from the sequencer to the shared unit.
    typedef struct packed {
        logic start;
        op_t  op;
    } unit_req_t;

    // Answer of the shared unit.
    typedef struct packed {
        logic               done;
        logic [LEVEL_W-1:0] result;
    } unit_rsp_t;

endpackage

`default_nettype wire

/* rtl/motion_activity_tracker.sv */
// Top level of the motion activity tracker: sequencer, state and output register.
// Depends on mat_pkg, mat_mul, mat_shsub and mat_ring.
//
// Channel  Direction  Handshake          Content
// s_*      in         s_tvalid/s_tready  tdata: accel_x, accel_y, accel_z
// m_*      out        m_tvalid/m_tready  tdata: magnitude, motion_level, window avg;
//                                        tuser: primed
// cfg_*    in         cfg_wr_en          smoothing_alpha
//
// The shared shift-subtract unit works in steps: 16 for the root and TW for
// the window division, TW = 32 + clog2(HISTORY_DEPTH + 1), 39 at the default
// depth. The first item after reset skips the level update and the division.
// s_tready is high only while the sequencer waits for an item. A finished result
// waits in the output register; the next item is accepted meanwhile, and the
// sequencer holds its own result until that register is free. Reset is
// asynchronous and active low; the history ring needs no clearing pass.
`default_nettype none

module motion_activity_tracker
    import mat_pkg::*;
#(
    parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    // accel_x [15:0], accel_y [31:16], accel_z [47:32]
    input  wire logic [47:0]  s_tdata,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // magnitude [15:0], motion_level [47:16], motion_window_avg [79:48]
    output logic      [79:0]  m_tdata,
    // primed [0]
    output logic      [0:0]   m_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    input  wire logic         cfg_wr_en,
    input  wire logic [15:0]  cfg_wr_data
);

    localparam int PW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int FW = $clog2(HISTORY_DEPTH + 1);
    localparam int TW = LEVEL_W + FW;

    typedef enum logic [13:0] {
        S_IDLE   = 14'b00000000000001,
        S_SQX    = 14'b00000000000010,
        S_SQY    = 14'b00000000000100,
        S_SQZ    = 14'b00000000001000,
        S_SQSUM  = 14'b00000000010000,
        S_ROOTGO = 14'b00000000100000,
        S_ROOT   = 14'b00000001000000,
        S_EMA1   = 14'b00000010000000,
        S_EMA2   = 14'b00000100000000,
        S_LEVEL  = 14'b00001000000000,
        S_STORE  = 14'b00010000000000,
        S_DIVGO  = 14'b00100000000000,
        S_DIVIDE = 14'b01000000000000,
        S_OUT    = 14'b10000000000000
    } state_t;

    state_t             state_reg, state_next;
    logic [ALPHA_W-1:0] alpha_reg, alpha_next;
    logic               first_reg, first_next;
    logic [MAG_W-1:0]   prev_reg, prev_next;
    logic [LEVEL_W-1:0] level_reg, level_next;
    logic [LEVEL_W-1:0] mean_reg, mean_next;
    logic [PW-1:0]      pos_reg, pos_next;
    logic [FW-1:0]      fill_reg, fill_next;
    logic [TW-1:0]      total_reg, total_next;
    logic               primed_reg, primed_next;
    logic               m_valid_reg, m_valid_next;

    logic [SAMPLE_W-1:0] ax_reg, ax_next;
    logic [SAMPLE_W-1:0] ay_reg, ay_next;
    logic [SAMPLE_W-1:0] az_reg, az_next;
    logic [SUMSQ_W-1:0]  sum_reg, sum_next;
    logic [MAG_W-1:0]    mag_reg, mag_next;
    logic [MAG_W-1:0]    delta_reg, delta_next;
    logic [LEVEL_W-1:0]  p1_reg, p1_next;
    logic [79:0]         m_data_reg, m_data_next;
    logic                m_user_reg, m_user_next;

    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [MUL_P_W-1:0] product;
    unit_req_t          unit_req;
    unit_rsp_t          unit_rsp;
    logic [TW-1:0]      unit_operand;
    logic               ring_rd_en;
    logic               ring_wr_en;
    logic [LEVEL_W-1:0] ring_rd_data;

    logic               accept;
    logic               ring_full;
    logic [MAG_W-1:0]   root_mag;

    assign accept    = s_tvalid && s_tready;
    assign ring_full = (fill_reg == FW'(HISTORY_DEPTH));
    assign root_mag  = unit_rsp.result[MAG_W-1:0];

    // Multiplier operands follow the sequencer state.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_SQX:
            begin
                mul_a = MUL_A_W'(ax_reg);
                mul_b = MUL_B_W'(ax_reg);
            end
            S_SQY:
            begin
                mul_a = MUL_A_W'(ay_reg);
                mul_b = MUL_B_W'(ay_reg);
            end
            S_SQZ:
            begin
                mul_a = MUL_A_W'(az_reg);
                mul_b = MUL_B_W'(az_reg);
            end
            S_EMA1:
            begin
                mul_a = MUL_A_W'(alpha_reg);
                mul_b = MUL_B_W'(delta_reg);
            end
            S_EMA2:
            begin
                mul_a = MUL_A_W'(18'h10000 - 18'(alpha_reg));
                mul_b = level_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Requests to the shared unit and the ring.
    always_comb
    begin
        unit_req.start = (state_reg == S_ROOTGO) || (state_reg == S_DIVGO);
        unit_req.op    = (state_reg == S_DIVGO) ? OP_DIV : OP_ROOT;
        unit_operand   = (state_reg == S_DIVGO) ? total_reg : TW'(sum_reg);
        ring_rd_en     = (state_reg == S_EMA1);
        ring_wr_en     = (state_reg == S_STORE);
    end

    // Sequencer and next-state values.
    always_comb
    begin
        state_next   = state_reg;
        alpha_next   = alpha_reg;
        first_next   = first_reg;
        prev_next    = prev_reg;
        level_next   = level_reg;
        mean_next    = mean_reg;
        pos_next     = pos_reg;
        fill_next    = fill_reg;
        total_next   = total_reg;
        primed_next  = primed_reg;
        m_valid_next = m_valid_reg;
        ax_next      = ax_reg;
        ay_next      = ay_reg;
        az_next      = az_reg;
        sum_next     = sum_reg;
        mag_next     = mag_reg;
        delta_next   = delta_reg;
        p1_next      = p1_reg;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;

        if (cfg_wr_en)
        begin
            alpha_next = cfg_wr_data;
        end

        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    // Absolute values of the axes; the most negative sample maps to 32768.
                    ax_next = s_tdata[15] ? SAMPLE_W'(~s_tdata[15:0] + 16'd1) : s_tdata[15:0];
                    ay_next = s_tdata[31] ? SAMPLE_W'(~s_tdata[31:16] + 16'd1)
                                          : s_tdata[31:16];
                    az_next = s_tdata[47] ? SAMPLE_W'(~s_tdata[47:32] + 16'd1)
                                          : s_tdata[47:32];
                    state_next = S_SQX;
                end
            end
            S_SQX:
            begin
                state_next = S_SQY;
            end
            S_SQY:
            begin
                sum_next   = product[SUMSQ_W-1:0];
                state_next = S_SQZ;
            end
            S_SQZ:
            begin
                sum_next   = sum_reg + product[SUMSQ_W-1:0];
                state_next = S_SQSUM;
            end
            S_SQSUM:
            begin
                sum_next   = sum_reg + product[SUMSQ_W-1:0];
                state_next = S_ROOTGO;
            end
            S_ROOTGO:
            begin
                state_next = S_ROOT;
            end
            S_ROOT:
            begin
                if (unit_rsp.done)
                begin
                    mag_next  = root_mag;
                    prev_next = root_mag;
                    if (first_reg)
                    begin
                        // The first sample only primes the previous magnitude.
                        first_next  = 1'b0;
                        primed_next = 1'b0;
                        state_next  = S_OUT;
                    end
                    else
                    begin
                        delta_next = (root_mag >= prev_reg) ? (root_mag - prev_reg)
                                                            : (prev_reg - root_mag);
                        state_next = S_EMA1;
                    end
                end
            end
            S_EMA1:
            begin
                state_next = S_EMA2;
            end
            S_EMA2:
            begin
                p1_next = product[LEVEL_W-1:0];
                // The oldest level, read in the previous cycle, leaves a full window.
                if (ring_full)
                begin
                    total_next = total_reg - TW'(ring_rd_data);
                end
                state_next = S_LEVEL;
            end
            S_LEVEL:
            begin
                // (alpha * delta << 16 + (1 - alpha) * level) >> 16, truncated.
                level_next = LEVEL_W'(33'(p1_reg) + 33'(product[MUL_P_W-1:16]));
                state_next = S_STORE;
            end
            S_STORE:
            begin
                total_next = total_reg + TW'(level_reg);
                pos_next   = (pos_reg == PW'(HISTORY_DEPTH - 1)) ? '0 : pos_reg + PW'(1);
                if (!ring_full)
                begin
                    fill_next = fill_reg + FW'(1);
                end
                state_next = S_DIVGO;
            end
            S_DIVGO:
            begin
                state_next = S_DIVIDE;
            end
            S_DIVIDE:
            begin
                if (unit_rsp.done)
                begin
                    mean_next   = unit_rsp.result;
                    primed_next = 1'b1;
                    state_next  = S_OUT;
                end
            end
            S_OUT:
            begin
                // Hand the result over once the output register is free.
                if (!m_valid_reg || m_tready)
                begin
                    m_data_next  = {mean_reg, level_reg, mag_reg};
                    m_user_next  = primed_reg;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control and architectural state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            alpha_reg   <= ALPHA_RESET;
            first_reg   <= 1'b1;
            prev_reg    <= '0;
            level_reg   <= '0;
            mean_reg    <= '0;
            pos_reg     <= '0;
            fill_reg    <= '0;
            total_reg   <= '0;
            primed_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            alpha_reg   <= alpha_next;
            first_reg   <= first_next;
            prev_reg    <= prev_next;
            level_reg   <= level_next;
            mean_reg    <= mean_next;
            pos_reg     <= pos_next;
            fill_reg    <= fill_next;
            total_reg   <= total_next;
            primed_reg  <= primed_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Working registers and output payload.
    always_ff @(posedge clk)
    begin
        ax_reg     <= ax_next;
        ay_reg     <= ay_next;
        az_reg     <= az_next;
        sum_reg    <= sum_next;
        mag_reg    <= mag_next;
        delta_reg  <= delta_next;
        p1_reg     <= p1_next;
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
    end

    mat_mul u_mul
    (
        .clk     (clk),
        .mul_a   (mul_a),
        .mul_b   (mul_b),
        .product (product)
    );

    mat_shsub
    #(
        .TW (TW),
        .FW (FW)
    )
    u_shsub
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (unit_req),
        .operand (unit_operand),
        .divisor (fill_reg),
        .rsp     (unit_rsp)
    );

    mat_ring
    #(
        .DEPTH (HISTORY_DEPTH),
        .PW    (PW)
    )
    u_ring
    (
        .clk     (clk),
        .rd_en   (ring_rd_en),
        .rd_addr (pos_reg),
        .rd_data (ring_rd_data),
        .wr_en   (ring_wr_en),
        .wr_addr (pos_reg),
        .wr_data (level_reg)
    );

    assign s_tready   = (state_reg == S_IDLE);
    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_data_reg;
    assign m_tuser[0] = m_user_reg;

endmodule

`default_nettype wire

/* rtl/mat_mul.sv */
// Registered 17 x 32 unsigned multiplier shared by the squaring and averaging steps.
// Depends on mat_pkg for operand widths.
`default_nettype none

module mat_mul
    import mat_pkg::*;
(
    input  wire logic               clk,
    input  wire logic [MUL_A_W-1:0] mul_a,
    input  wire logic [MUL_B_W-1:0] mul_b,
    output logic      [MUL_P_W-1:0] product
);

    logic [MUL_P_W-1:0] product_reg;

    // The product is registered: it is ready in the cycle after the operands are presented.
    always_ff @(posedge clk)
    begin
        product_reg <= MUL_P_W'(mul_a) * MUL_P_W'(mul_b);
    end

    assign product = product_reg;

endmodule

`default_nettype wire

/* rtl/mat_shsub.sv */
// Shared shift-subtract unit: floor square root or restoring division, one digit a cycle.
// Depends on mat_pkg for the request and answer structs and the operation codes.
`default_nettype none

module mat_shsub
    import mat_pkg::*;
#(
    parameter int TW = 39,
    parameter int FW = 7
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire unit_req_t     req,
    input  wire logic [TW-1:0] operand,
    input  wire logic [FW-1:0] divisor,
    output unit_rsp_t          rsp
);

    // The partial remainder needs 19 bits for the root and FW + 1 for division.
    localparam int RW = (FW + 1 > 20) ? FW + 1 : 20;
    localparam int CW = $clog2(TW + 1);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] count_reg, count_next;
    op_t           op_reg, op_next;
    logic [TW-1:0] src_reg, src_next;
    logic [RW-1:0] rem_reg, rem_next;
    logic [TW-1:0] acc_reg, acc_next;
    logic [FW-1:0] div_reg, div_next;

    logic [RW-1:0] rem_sh;
    logic [RW-1:0] sub;
    logic [RW:0]   diff;
    logic          fits;

    // One recurrence step: bring in the next digit and try the subtraction.
    always_comb
    begin
        if (op_reg == OP_ROOT)
        begin
            rem_sh = {rem_reg[RW-3:0], src_reg[TW-1 -: 2]};
            sub    = {acc_reg[RW-3:0], 2'b01};
        end
        else
        begin
            rem_sh = {rem_reg[RW-2:0], src_reg[TW-1]};
            sub    = RW'(div_reg);
        end
        diff = {1'b0, rem_sh} - {1'b0, sub};
        fits = ~diff[RW];
    end

    // Load on start, then step until the count runs out.
    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        count_next = count_reg;
        op_next    = op_reg;
        src_next   = src_reg;
        rem_next   = rem_reg;
        acc_next   = acc_reg;
        div_next   = div_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            op_next   = req.op;
            rem_next  = '0;
            acc_next  = '0;
            div_next  = divisor;
            if (req.op == OP_ROOT)
            begin
                // Align the 32-bit radicand with the top of the source register.
                src_next   = operand << (TW - SUMSQ_W);
                count_next = CW'(ROOT_STEPS);
            end
            else
            begin
                src_next   = operand;
                count_next = CW'(TW);
            end
        end
        else if (busy_reg)
        begin
            rem_next   = fits ? diff[RW-1:0] : rem_sh;
            acc_next   = {acc_reg[TW-2:0], fits};
            src_next   = (op_reg == OP_ROOT) ? (src_reg << 2) : (src_reg << 1);
            count_next = count_reg - CW'(1);
            if (count_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
            op_reg    <= OP_ROOT;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
            op_reg    <= op_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        src_reg <= src_next;
        rem_reg <= rem_next;
        acc_reg <= acc_next;
        div_reg <= div_next;
    end

    assign rsp.done   = done_reg;
    assign rsp.result = acc_reg[LEVEL_W-1:0];

endmodule

`default_nettype wire

/* rtl/mat_ring.sv */
// History ring of motion levels: one write port and one registered read port.
// Depends on mat_pkg for the level width.
`default_nettype none

module mat_ring
    import mat_pkg::*;
#(
    parameter int DEPTH = 100,
    parameter int PW    = 7
)
(
    input  wire logic               clk,
    input  wire logic               rd_en,
    input  wire logic [PW-1:0]      rd_addr,
    output logic      [LEVEL_W-1:0] rd_data,
    input  wire logic               wr_en,
    input  wire logic [PW-1:0]      wr_addr,
    input  wire logic [LEVEL_W-1:0] wr_data
);

    logic [LEVEL_W-1:0] mem [DEPTH];
    logic [LEVEL_W-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port; the data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire
